@@ src/evgrp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evgrp_pkg
// shared types, codes and defaults for the event flag group
// ----------------------------------------------------------------------------
package evgrp_pkg;

  localparam int EVG_WAITERS      = 8;
  localparam int EVG_TASK_ID_BITS = 8;

  localparam int OP_W   = 2;
  localparam int KIND_W = 3;
  localparam int TID_W  = 8;
  localparam int WORD_W = 32;

  // request codes
  localparam logic [OP_W-1:0] OP_WAIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

  // result codes
  localparam logic [KIND_W-1:0] KIND_SATISFIED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FAILED    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WOKEN     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TIMEDOUT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DONE      = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSCAN,
    ST_WEMIT,
    ST_SCAN,
    ST_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take a new transaction
    logic wscan;  // presence check of one table entry
    logic wemit;  // issue the wait result, queue if needed
    logic step;   // set or tick visit of one table entry
    logic fin;    // issue the done result, commit the table size after a set or tick
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_end;   // scan index has reached the waiter count
    logic leave;    // current entry leaves the table
    logic out_room; // output register can take a result this cycle
    logic count_ok; // waiter count within table size
  } sts_t;

endpackage

@@ src/evgrp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evgrp_ctrl
// sequencer for wait, set, clear and tick transactions
// ----------------------------------------------------------------------------
module evgrp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [evgrp_pkg::OP_W-1:0] op,
  input  evgrp_pkg::sts_t            sts,
  output evgrp_pkg::cmd_t            cmd
);

  evgrp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= evgrp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      evgrp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (op)
            evgrp_pkg::OP_WAIT:  state_next = evgrp_pkg::ST_WSCAN;
            evgrp_pkg::OP_CLEAR: state_next = evgrp_pkg::ST_FIN;
            default:             state_next = evgrp_pkg::ST_SCAN;
          endcase
        end
      end
      evgrp_pkg::ST_WSCAN: begin
        if (sts.at_end) begin
          state_next = evgrp_pkg::ST_WEMIT;
        end else begin
          cmd.wscan = 1'b1;
        end
      end
      evgrp_pkg::ST_WEMIT: begin
        if (sts.out_room) begin
          cmd.wemit  = 1'b1;
          state_next = evgrp_pkg::ST_IDLE;
        end
      end
      evgrp_pkg::ST_SCAN: begin
        if (sts.at_end) begin
          state_next = evgrp_pkg::ST_FIN;
        end else if (!sts.leave || sts.out_room) begin
          cmd.step = 1'b1;
        end
      end
      evgrp_pkg::ST_FIN: begin
        if (sts.out_room) begin
          cmd.fin    = 1'b1;
          state_next = evgrp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = evgrp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/evgrp_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evgrp_dp
// flag word, waiter table with scan and compaction, result register
// ----------------------------------------------------------------------------
module evgrp_dp #(
  parameter int WAITERS      = evgrp_pkg::EVG_WAITERS,
  parameter int TASK_ID_BITS = evgrp_pkg::EVG_TASK_ID_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  evgrp_pkg::cmd_t              cmd,
  output evgrp_pkg::sts_t              sts,
  input  logic [evgrp_pkg::OP_W-1:0]   op,
  input  logic [evgrp_pkg::TID_W-1:0]  task_id,
  input  logic [evgrp_pkg::WORD_W-1:0] mask,
  input  logic [evgrp_pkg::WORD_W-1:0] timeout,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [evgrp_pkg::TID_W-1:0]  task_id_res,
  output logic [evgrp_pkg::KIND_W-1:0] kind,
  output logic [evgrp_pkg::WORD_W-1:0] flags,
  output logic                         last
);

  localparam int CW = $clog2(WAITERS + 1);
  localparam int IW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int TW = (TASK_ID_BITS < evgrp_pkg::TID_W) ? TASK_ID_BITS : evgrp_pkg::TID_W;
  localparam logic [CW-1:0] FULL = CW'(WAITERS);

  // waiter table
  logic [TW-1:0]                tab_task  [WAITERS];
  logic [evgrp_pkg::WORD_W-1:0] tab_mask  [WAITERS];
  logic [evgrp_pkg::WORD_W-1:0] tab_ticks [WAITERS];

  logic [evgrp_pkg::WORD_W-1:0] event_flags;
  logic [CW-1:0]                count;
  logic [CW-1:0]                idx;
  logic [CW-1:0]                keep;
  logic                         present;

  // latched request
  logic [evgrp_pkg::OP_W-1:0]   op_q;
  logic [TW-1:0]                task_q;
  logic [evgrp_pkg::WORD_W-1:0] mask_q;
  logic [evgrp_pkg::WORD_W-1:0] timeout_q;

  logic [TW-1:0]                cur_task;
  logic [evgrp_pkg::WORD_W-1:0] cur_mask;
  logic [evgrp_pkg::WORD_W-1:0] cur_ticks;
  logic [evgrp_pkg::WORD_W-1:0] ticks_dec;
  logic                         leave;
  logic [evgrp_pkg::KIND_W-1:0] wkind;
  logic                         out_room;

  assign cur_task  = tab_task[idx[IW-1:0]];
  assign cur_mask  = tab_mask[idx[IW-1:0]];
  assign cur_ticks = tab_ticks[idx[IW-1:0]];
  assign ticks_dec = (cur_ticks != '0) ? cur_ticks - 1'b1 : cur_ticks;

  always_comb begin
    if (op_q == evgrp_pkg::OP_SET) begin
      leave = (event_flags & cur_mask) != '0;
    end else begin
      leave = ticks_dec == '0;
    end
  end

  always_comb begin
    if ((event_flags & mask_q) != '0) begin
      wkind = evgrp_pkg::KIND_SATISFIED;
    end else if (timeout_q == '0) begin
      wkind = evgrp_pkg::KIND_FAILED;
    end else if (present || count >= FULL) begin
      wkind = evgrp_pkg::KIND_REJECTED;
    end else begin
      wkind = evgrp_pkg::KIND_QUEUED;
    end
  end

  assign out_room     = !out_valid || out_ready;
  assign sts.at_end   = idx == count;
  assign sts.leave    = leave;
  assign sts.out_room = out_room;
  assign sts.count_ok = count <= FULL;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      event_flags <= '0;
      count       <= '0;
      idx         <= '0;
      keep        <= '0;
      present     <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx     <= '0;
        keep    <= '0;
        present <= 1'b0;
        if (op == evgrp_pkg::OP_SET) begin
          event_flags <= event_flags | mask;
        end else if (op == evgrp_pkg::OP_CLEAR) begin
          event_flags <= event_flags & ~mask;
        end
      end
      if (cmd.wscan) begin
        idx <= idx + 1'b1;
        if (cur_task == task_q) begin
          present <= 1'b1;
        end
      end
      if (cmd.wemit && wkind == evgrp_pkg::KIND_QUEUED) begin
        count <= count + 1'b1;
      end
      if (cmd.step) begin
        idx <= idx + 1'b1;
        if (!leave) begin
          keep <= keep + 1'b1;
        end
      end
      if (cmd.fin && (op_q == evgrp_pkg::OP_SET || op_q == evgrp_pkg::OP_TICK)) begin
        count <= keep;
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op;
      task_q    <= task_id[TW-1:0];
      mask_q    <= mask;
      timeout_q <= timeout;
    end
  end

  // table writes: append on queue, compaction during a scan
  always_ff @(posedge clk) begin
    if (cmd.wemit && wkind == evgrp_pkg::KIND_QUEUED) begin
      tab_task[count[IW-1:0]]  <= task_q;
      tab_mask[count[IW-1:0]]  <= mask_q;
      tab_ticks[count[IW-1:0]] <= timeout_q;
    end else if (cmd.step && !leave) begin
      tab_task[keep[IW-1:0]]  <= cur_task;
      tab_mask[keep[IW-1:0]]  <= cur_mask;
      tab_ticks[keep[IW-1:0]] <= (op_q == evgrp_pkg::OP_TICK) ? ticks_dec : cur_ticks;
    end
  end

  // result register
  logic emit;
  assign emit = cmd.wemit || cmd.fin || (cmd.step && leave);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      flags <= event_flags;
      if (cmd.wemit) begin
        task_id_res <= evgrp_pkg::TID_W'(task_q);
        kind        <= wkind;
        last        <= 1'b1;
      end else if (cmd.fin) begin
        task_id_res <= '0;
        kind        <= evgrp_pkg::KIND_DONE;
        last        <= 1'b1;
      end else begin
        task_id_res <= evgrp_pkg::TID_W'(cur_task);
        kind        <= (op_q == evgrp_pkg::OP_SET) ? evgrp_pkg::KIND_WOKEN
                                                   : evgrp_pkg::KIND_TIMEDOUT;
        last        <= 1'b0;
      end
    end
  end

endmodule

@@ src/event_flag_group_with_waiters.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_flag_group_with_waiters
// hardware event group: 32-bit flag word and an ordered table of waiters
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one request transaction: op,
//   task_id, mask, timeout. op selects wait, set, clear or tick
//   output channel (out_valid/out_ready) carries result transactions:
//   task_id_res, kind, flags, last. every request yields one or more results,
//   the final one marked by last
//   a wait gives a single result; a set gives one woken result per released
//   waiter then a done result; a tick does the same for expired waiters;
//   a clear gives one done result
// sequencing
//   the waiter table is visited one entry per cycle, but a set or tick scan
//   holds at an entry that leaves while the output register has no room;
//   after the last entry the scan sees the end of the table, then the wait
//   or done result is issued. a clear goes straight to its done result
//   one request is in progress at a time; the next is taken as soon as the
//   last result has been placed in the output register
// reset
//   synchronous rst empties the table and clears the flag word
// stalls
//   while out_ready is low and a result waits, the scan holds at the next
//   entry that has a result to issue
// ----------------------------------------------------------------------------
module event_flag_group_with_waiters #(
  parameter int WAITERS      = evgrp_pkg::EVG_WAITERS,
  parameter int TASK_ID_BITS = evgrp_pkg::EVG_TASK_ID_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [evgrp_pkg::OP_W-1:0]   op,
  input  logic [evgrp_pkg::TID_W-1:0]  task_id,
  input  logic [evgrp_pkg::WORD_W-1:0] mask,
  input  logic [evgrp_pkg::WORD_W-1:0] timeout,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [evgrp_pkg::TID_W-1:0]  task_id_res,
  output logic [evgrp_pkg::KIND_W-1:0] kind,
  output logic [evgrp_pkg::WORD_W-1:0] flags,
  output logic                         last
);

  // command and status between sequencer and datapath
  evgrp_pkg::cmd_t cmd;
  evgrp_pkg::sts_t sts;

  // sequencer: walks each request through scan and result issue
  evgrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: flag word, waiter table, output register
  evgrp_dp #(
    .WAITERS      (WAITERS),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .task_id     (task_id),
    .mask        (mask),
    .timeout     (timeout),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .task_id_res (task_id_res),
    .kind        (kind),
    .flags       (flags),
    .last        (last)
  );

`ifndef NO_ASSERTIONS
  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.wscan, cmd.wemit, cmd.step, cmd.fin}))
    else $error("more than one datapath command in a cycle");

  // a result is only issued when the output register has room
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.wemit || cmd.fin || (cmd.step && sts.leave)) |-> sts.out_room)
    else $error("result issued into a full output register");

  // an accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while a previous one is still in progress");

  // table never holds more than its size
  a_count: assert property (@(posedge clk) disable iff (rst)
    sts.count_ok)
    else $error("waiter count exceeds table size");
`endif

endmodule

@@ dv/event_flag_group_with_waiters_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_flag_group_with_waiters_tb
// self-checking bench for the event group with its table of waiting tasks
// ----------------------------------------------------------------------------
// a directed sequence walks through every request code and the corner cases:
// empty wait masks, zero timeouts, a task that already waits, a full table
// and the done transaction. random traffic follows in phases with and without
// sender gaps and receiver stalls, plus one long receiver hold-off. an
// in-bench model of the flag word and the waiter table predicts every result
// transaction, which is checked in order against the result channel
// ----------------------------------------------------------------------------
module event_flag_group_with_waiters_tb;
  import evgrp_pkg::*;

  localparam int WAITERS  = EVG_WAITERS;
  localparam int TID_KEEP = (1 << EVG_TASK_ID_BITS) - 1;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [TID_W-1:0]  tid;
    logic [WORD_W-1:0] req_mask;
    logic [WORD_W-1:0] req_ticks;
  } request_t;

  typedef struct {
    logic [TID_W-1:0]  tid;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] flags;
    logic              last;
  } outcome_t;

  // block ports, all inputs known from time zero
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op        = OP_WAIT;
  logic [TID_W-1:0]  task_id   = '0;
  logic [WORD_W-1:0] mask      = '0;
  logic [WORD_W-1:0] timeout   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [TID_W-1:0]  task_id_res;
  logic [KIND_W-1:0] kind;
  logic [WORD_W-1:0] flags;
  logic              last;

  // mirror of the event group: flag word and waiter table in queue order
  logic [WORD_W-1:0] flag_word = '0;
  int                table_len = 0;
  logic [TID_W-1:0]  tab_task  [WAITERS];
  logic [WORD_W-1:0] tab_mask  [WAITERS];
  logic [WORD_W-1:0] tab_ticks [WAITERS];

  outcome_t pending_results[$];
  outcome_t want;

  // traffic shaping, set by the test tasks; the hold-off is counted down on the result side
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  int requests_sent   = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int kind_seen [8];

  event_flag_group_with_waiters dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .task_id     (task_id),
    .mask        (mask),
    .timeout     (timeout),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .task_id_res (task_id_res),
    .kind        (kind),
    .flags       (flags),
    .last        (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // model of the event group
  // ------------------------------------------------------------------------

  function automatic void push_outcome(logic [TID_W-1:0] tid, logic [KIND_W-1:0] k,
                                       logic lst);
    outcome_t o;
    o.tid   = tid;
    o.kind  = k;
    o.flags = flag_word;
    o.last  = lst;
    pending_results.push_back(o);
  endfunction

  // one request transaction: update the mirror and queue the results it causes
  function automatic void apply_request(logic [OP_W-1:0] op_i, logic [TID_W-1:0] tid_i,
                                        logic [WORD_W-1:0] mask_i,
                                        logic [WORD_W-1:0] ticks_i);
    logic [TID_W-1:0] tid;
    logic             present;
    logic             leave;
    int               keep;
    int               i;
    tid     = tid_i & TID_W'(TID_KEEP);
    present = 1'b0;
    keep    = 0;
    case (op_i)
      OP_WAIT: begin
        for (i = 0; i < table_len; i++)
          if (tab_task[i] == tid) present = 1'b1;
        // precedence: satisfied, then no-wait failure, then rejection
        if ((flag_word & mask_i) != '0) begin
          push_outcome(tid, KIND_SATISFIED, 1'b1);
        end else if (ticks_i == '0) begin
          push_outcome(tid, KIND_FAILED, 1'b1);
        end else if (present || table_len >= WAITERS) begin
          push_outcome(tid, KIND_REJECTED, 1'b1);
        end else begin
          tab_task[table_len]  = tid;
          tab_mask[table_len]  = mask_i;
          tab_ticks[table_len] = ticks_i;
          table_len++;
          push_outcome(tid, KIND_QUEUED, 1'b1);
        end
      end
      OP_CLEAR: begin
        flag_word &= ~mask_i;
        push_outcome('0, KIND_DONE, 1'b1);
      end
      default: begin
        if (op_i == OP_SET) flag_word |= mask_i;
        // visit in queue order, report leavers, compact the survivors
        for (i = 0; i < table_len; i++) begin
          if (op_i == OP_SET) begin
            leave = (flag_word & tab_mask[i]) != '0;
          end else begin
            if (tab_ticks[i] != '0) tab_ticks[i] = tab_ticks[i] - 1;
            leave = tab_ticks[i] == '0;
          end
          if (leave) begin
            push_outcome(tab_task[i], (op_i == OP_SET) ? KIND_WOKEN : KIND_TIMEDOUT, 1'b0);
          end else begin
            tab_task[keep]  = tab_task[i];
            tab_mask[keep]  = tab_mask[i];
            tab_ticks[keep] = tab_ticks[i];
            keep++;
          end
        end
        table_len = keep;
        push_outcome('0, KIND_DONE, 1'b1);
      end
    endcase
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, msg);
  endfunction

  // ------------------------------------------------------------------------
  // port watcher: check results first, then predict from the accepted request
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result tid %0d kind %0d flags %h last %b",
                                  task_id_res, kind, flags, last));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          kind_seen[want.kind]++;
          if (task_id_res !== want.tid || kind !== want.kind ||
              flags !== want.flags || last !== want.last)
            flag_mismatch($sformatf(
              "expected tid %0d kind %0d flags %h last %b, got tid %0d kind %0d flags %h last %b",
              want.tid, want.kind, want.flags, want.last,
              task_id_res, kind, flags, last));
        end
      end
      if (in_valid && in_ready) apply_request(op, task_id, mask, timeout);
    end
  end

  // result side: random stalls, or a long hold-off counted here when asked for
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ------------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------------

  function automatic request_t make_request(logic [OP_W-1:0] o, logic [TID_W-1:0] t,
                                            logic [WORD_W-1:0] m, logic [WORD_W-1:0] tk);
    request_t r;
    r.op        = o;
    r.tid       = t;
    r.req_mask  = m;
    r.req_ticks = tk;
    return r;
  endfunction

  // mostly small task ids, sparse masks and short timeouts so that the table
  // fills, waiters collide, get woken and expire; the rest is wide noise
  function automatic request_t random_request();
    request_t r;
    int       sel;
    sel = $urandom_range(99);
    if (sel < 42)      r.op = OP_WAIT;
    else if (sel < 62) r.op = OP_SET;
    else if (sel < 74) r.op = OP_CLEAR;
    else               r.op = OP_TICK;
    r.tid = ($urandom_range(9) < 8) ? TID_W'($urandom_range(11)) : TID_W'($urandom_range(255));
    sel = $urandom_range(9);
    if (sel == 0)      r.req_mask = '0;
    else if (sel == 1) r.req_mask = '1;
    else if (sel < 4)  r.req_mask = $urandom;
    else               r.req_mask = (32'd1 << $urandom_range(31)) |
                                    (($urandom_range(1) == 1) ? (32'd1 << $urandom_range(31)) : '0);
    // clears mostly wipe wide, so waits are not all satisfied at once
    if (r.op == OP_CLEAR && $urandom_range(1) == 1) r.req_mask = '1;
    sel = $urandom_range(19);
    if (sel < 2)                         r.req_ticks = '0;
    else if (sel == 2 && r.req_mask != '0) r.req_ticks = $urandom;
    else if (sel == 3 && r.req_mask != '0) r.req_ticks = '1;
    else                                 r.req_ticks = $urandom_range(6, 1);
    return r;
  endfunction

  // offer one request transaction and hold it until it is taken
  task automatic send_request(input request_t r);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    op       = r.op;
    task_id  = r.tid;
    mask     = r.req_mask;
    timeout  = r.req_ticks;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  task automatic test_directed();
    int k;
    idle_pct  = 0;
    stall_pct = 0;
    // empty mask with zero timeout fails, with a timeout it queues and expires
    send_request(make_request(OP_WAIT, 8'd0, 32'h0, 32'h0));
    send_request(make_request(OP_WAIT, 8'd0, 32'h0, 32'h1));
    send_request(make_request(OP_TICK, 8'd0, 32'h0, 32'h0));
    // all flags up, top bit satisfies at once, empty mask still queues
    send_request(make_request(OP_SET, 8'd0, 32'hFFFF_FFFF, 32'h0));
    send_request(make_request(OP_WAIT, 8'd3, 32'h8000_0000, 32'h0));
    send_request(make_request(OP_WAIT, 8'd4, 32'h0, 32'h5));
    send_request(make_request(OP_CLEAR, 8'd0, 32'hFFFF_FFFF, 32'h0));
    // top task id with the longest timeout, then the same task again
    send_request(make_request(OP_WAIT, 8'd255, 32'h1, 32'hFFFF_FFFF));
    send_request(make_request(OP_WAIT, 8'd255, 32'h2, 32'h3));
    // queue more waiters; task 4 already waits and is rejected
    for (k = 1; k <= 6; k++)
      send_request(make_request(OP_WAIT, TID_W'(k), 32'd1 << (4 * k), WORD_W'(k)));
    // the last free entry takes task 200, then a zero timeout reports a failure
    send_request(make_request(OP_WAIT, 8'd200, 32'h4, 32'h9));
    send_request(make_request(OP_WAIT, 8'd200, 32'h0, 32'h0));
    // wake two waiters out of the middle of the queue
    send_request(make_request(OP_SET, 8'd0, 32'h0000_0011, 32'h0));
    send_request(make_request(OP_TICK, 8'd0, 32'h0, 32'h0));
    send_request(make_request(OP_TICK, 8'd0, 32'h0, 32'h0));
    // no-op set and clear still give a done transaction
    send_request(make_request(OP_SET, 8'd0, 32'h0, 32'h0));
    send_request(make_request(OP_CLEAR, 8'd0, 32'h0, 32'h0));
    // wake everyone with a non-empty mask
    send_request(make_request(OP_SET, 8'd0, 32'hFFFF_FFFF, 32'h0));
    send_request(make_request(OP_TICK, 8'd0, 32'h0, 32'h0));
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    int k;
    idle_pct  = idle;
    stall_pct = stall;
    for (k = 0; k < n; k++) send_request(random_request());
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    int k;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    for (k = 0; k < 16; k++) send_request(random_request());
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin : run_tests
    int wait_cycles;
    wait_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    test_directed();
    test_random(100, 0, 0);
    test_random(100, 80, 0);
    test_backpressure();
    test_random(100, 0, 80);
    test_random(100, 8, 8);

    @(negedge clk) in_valid = 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    // a little longer, so that stray transactions would still be caught
    repeat (4 * (WAITERS + 2)) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d requests over idle-free, sender-gap, receiver-stall, mixed and",
             requests_sent);
    $display("long hold-off phases; %0d results: %0d satisfied %0d failed %0d queued",
             results_checked, kind_seen[KIND_SATISFIED], kind_seen[KIND_FAILED],
             kind_seen[KIND_QUEUED]);
    $display("  %0d woken %0d timed out %0d rejected %0d done",
             kind_seen[KIND_WOKEN], kind_seen[KIND_TIMEDOUT],
             kind_seen[KIND_REJECTED], kind_seen[KIND_DONE]);
    if (mismatches == 0) begin
      $display("** event_flag_group_with_waiters: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** event_flag_group_with_waiters: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("** event_flag_group_with_waiters: FAILED **");
    $finish;
  end

endmodule

@@ event_flag_group_with_waiters.f @@
src/evgrp_pkg.sv
src/evgrp_ctrl.sv
src/evgrp_dp.sv
src/event_flag_group_with_waiters.sv
dv/event_flag_group_with_waiters_tb.sv
